[rtl/core/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the tick-driven I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int unsigned DELAY_WIDTH = 16;
	localparam int unsigned CFG_WIDTH   = 16;
	localparam logic [CFG_WIDTH-1:0] DELAY_RESET = 16'd500;
	localparam int unsigned BITS_PER_BYTE = 8;
	localparam logic [0:0] REG_DELAY = 1'b0;

	typedef enum logic [2:0] {
		CMD_NONE      = 3'd0,
		CMD_START     = 3'd1,
		CMD_WRITE     = 3'd2,
		CMD_READ_ACK  = 3'd3,
		CMD_READ_NACK = 3'd4,
		CMD_STOP      = 3'd5
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_START_A    = 4'd1,
		PH_START_B    = 4'd2,
		PH_START_C    = 4'd3,
		PH_BIT_HIGH   = 4'd4,
		PH_BIT_LOW    = 4'd5,
		PH_NINTH_HIGH = 4'd6,
		PH_NINTH_LOW  = 4'd7,
		PH_STOP_A     = 4'd8,
		PH_STOP_B     = 4'd9
	} phase_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] wdata;
		logic       sda_in;
	} cmd_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_released;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rdata;
		logic       acked;
	} res_item_t;

	// Entry of the queue between the front and the back, command already decoded.
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] wdata;
		logic       sda_in;
	} tick_t;

	// Queue status handed to the back.
	typedef struct packed {
		logic  valid;
		tick_t tick;
	} queue_head_t;

	function automatic cmd_t decode_func(input logic [2:0] func);
		cmd_t c;
		unique case (func)
			CMD_START, CMD_WRITE, CMD_READ_ACK, CMD_READ_NACK, CMD_STOP: c = cmd_t'(func);
			default: c = CMD_NONE;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/i2cm_front.sv]
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts tick beats, decodes the function code and holds them in a
// two-entry queue for the bus sequencer.
// ----------------------------------------------------------------------------
module i2cm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  i2cm_pkg::cmd_item_t   cmd,
	output i2cm_pkg::queue_head_t head,
	input  logic                  pop
);

	i2cm_pkg::tick_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign cmd_ready = (count_q != 2'd2);
	assign push      = cmd_valid && cmd_ready;

	assign head.valid = (count_q != 2'd0);
	assign head.tick  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q].cmd    <= i2cm_pkg::decode_func(cmd.func);
			entry_q[wr_ptr_q].wdata  <= cmd.wdata;
			entry_q[wr_ptr_q].sda_in <= cmd.sda_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[rtl/core/i2cm_back.sv]
// ----------------------------------------------------------------------------
// i2cm_back
// Bus sequencer: steps the half-bit phase machine once per tick beat and
// registers the pin levels and status as one result beat.
// ----------------------------------------------------------------------------
module i2cm_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [i2cm_pkg::CFG_WIDTH-1:0]      delay_ticks,
	input  i2cm_pkg::queue_head_t               head,
	output logic                                pop,
	output logic                                res_valid,
	input  logic                                res_ready,
	output i2cm_pkg::res_item_t                 res
);

	localparam int unsigned DW = i2cm_pkg::DELAY_WIDTH;

	i2cm_pkg::phase_t phase_q, phase_n;
	i2cm_pkg::cmd_t   command_q, command_n;
	logic [3:0]       bit_count_q, bit_count_n;
	logic [7:0]       shift_q, shift_n;
	logic [DW-1:0]    wait_q, wait_n;
	logic             scl_q, scl_n;
	logic             sda_q, sda_n;
	logic             rel_q, rel_n;
	logic [7:0]       read_byte_q, read_byte_n;
	logic             ack_q, ack_n;
	logic             done_n;
	logic             res_valid_q;
	i2cm_pkg::res_item_t res_q, res_n;

	logic [i2cm_pkg::CFG_WIDTH-1:0] delay_m1;
	logic [DW-1:0]                  reload;
	logic                           is_read;
	logic [3:0]                     bit_inc;

	// A zero delay behaves as one tick per phase.
	assign delay_m1 = (delay_ticks == '0) ? '0 : delay_ticks - i2cm_pkg::CFG_WIDTH'(1);
	assign reload   = DW'(delay_m1);
	assign is_read  = (command_q == i2cm_pkg::CMD_READ_ACK) ||
	                  (command_q == i2cm_pkg::CMD_READ_NACK);
	assign bit_inc  = bit_count_q + 4'd1;

	assign pop       = head.valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Next state of the sequencer for the tick at the queue head.
	always_comb begin
		phase_n     = phase_q;
		command_n   = command_q;
		bit_count_n = bit_count_q;
		shift_n     = shift_q;
		wait_n      = wait_q;
		scl_n       = scl_q;
		sda_n       = sda_q;
		rel_n       = rel_q;
		read_byte_n = read_byte_q;
		ack_n       = ack_q;
		done_n      = 1'b0;
		if (phase_q == i2cm_pkg::PH_IDLE) begin
			unique case (head.tick.cmd)
				i2cm_pkg::CMD_START: begin
					scl_n   = 1'b1;
					sda_n   = 1'b1;
					rel_n   = 1'b0;
					phase_n = i2cm_pkg::PH_START_A;
					wait_n  = reload;
				end
				i2cm_pkg::CMD_WRITE: begin
					shift_n     = head.tick.wdata;
					bit_count_n = 4'd0;
					rel_n       = 1'b0;
					sda_n       = head.tick.wdata[7];
					scl_n       = 1'b1;
					phase_n     = i2cm_pkg::PH_BIT_HIGH;
					wait_n      = reload;
				end
				i2cm_pkg::CMD_READ_ACK, i2cm_pkg::CMD_READ_NACK: begin
					shift_n     = 8'd0;
					bit_count_n = 4'd0;
					rel_n       = 1'b1;
					scl_n       = 1'b1;
					phase_n     = i2cm_pkg::PH_BIT_HIGH;
					wait_n      = reload;
				end
				i2cm_pkg::CMD_STOP: begin
					rel_n   = 1'b0;
					sda_n   = 1'b0;
					scl_n   = 1'b1;
					phase_n = i2cm_pkg::PH_STOP_A;
					wait_n  = reload;
				end
				default: begin
				end
			endcase
			if (head.tick.cmd != i2cm_pkg::CMD_NONE) begin
				command_n = head.tick.cmd;
			end
		end else if (wait_q != '0) begin
			wait_n = wait_q - DW'(1);
		end else begin
			unique case (phase_q)
				i2cm_pkg::PH_START_A: begin
					sda_n   = 1'b0;
					phase_n = i2cm_pkg::PH_START_B;
					wait_n  = reload;
				end
				i2cm_pkg::PH_START_B: begin
					scl_n   = 1'b0;
					phase_n = i2cm_pkg::PH_START_C;
					wait_n  = reload;
				end
				i2cm_pkg::PH_BIT_HIGH: begin
					if (is_read) begin
						shift_n = {shift_q[6:0], head.tick.sda_in};
					end
					scl_n   = 1'b0;
					phase_n = i2cm_pkg::PH_BIT_LOW;
					wait_n  = reload;
				end
				i2cm_pkg::PH_BIT_LOW: begin
					bit_count_n = bit_inc;
					scl_n       = 1'b1;
					wait_n      = reload;
					if (bit_inc < 4'(i2cm_pkg::BITS_PER_BYTE)) begin
						if (!is_read) begin
							shift_n = {shift_q[6:0], 1'b0};
							sda_n   = shift_q[6];
						end
						phase_n = i2cm_pkg::PH_BIT_HIGH;
					end else begin
						if (is_read) begin
							rel_n = 1'b0;
							sda_n = (command_q == i2cm_pkg::CMD_READ_NACK);
						end else begin
							rel_n = 1'b1;
						end
						phase_n = i2cm_pkg::PH_NINTH_HIGH;
					end
				end
				i2cm_pkg::PH_NINTH_HIGH: begin
					if (is_read) begin
						read_byte_n = shift_q;
					end else begin
						ack_n = ~head.tick.sda_in;
					end
					scl_n   = 1'b0;
					rel_n   = 1'b0;
					sda_n   = 1'b1;
					phase_n = i2cm_pkg::PH_NINTH_LOW;
					wait_n  = reload;
				end
				i2cm_pkg::PH_STOP_A: begin
					sda_n   = 1'b1;
					phase_n = i2cm_pkg::PH_STOP_B;
					wait_n  = reload;
				end
				default: begin
					// Last phase of a command ends here.
					phase_n = i2cm_pkg::PH_IDLE;
					done_n  = 1'b1;
				end
			endcase
		end
	end

	// Result beat assembled from the updated state.
	always_comb begin
		res_n.scl_out      = scl_n;
		res_n.sda_out      = sda_n;
		res_n.sda_released = rel_n;
		res_n.busy_res     = (phase_n != i2cm_pkg::PH_IDLE);
		res_n.done_res     = done_n;
		res_n.rdata        = read_byte_n;
		res_n.acked        = ack_n;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cm_pkg::PH_IDLE;
			command_q   <= i2cm_pkg::CMD_NONE;
			bit_count_q <= 4'd0;
			shift_q     <= 8'd0;
			wait_q      <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			rel_q       <= 1'b0;
			read_byte_q <= 8'd0;
			ack_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_n;
				command_q   <= command_n;
				bit_count_q <= bit_count_n;
				shift_q     <= shift_n;
				wait_q      <= wait_n;
				scl_q       <= scl_n;
				sda_q       <= sda_n;
				rel_q       <= rel_n;
				read_byte_q <= read_byte_n;
				ack_q       <= ack_n;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/i2c_master_byte_engine.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Tick-driven I2C master: one input beat per clock tick, one result beat of
// pin levels and status per input beat.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   cmd       in         cmd_valid/cmd_ready  func, wdata, sda_in
//   res       out        res_valid/res_ready  scl_out, sda_out, sda_released,
//                                             busy_res, done_res, rdata, acked
//   apb       in         psel/penable/pready  delay_ticks at byte address 0
//
// One beat is taken per clock and one result beat leaves per clock when
// neither side stalls; a beat is held first in the front queue and then in
// the result register. The sequencer's single-step update is the only
// loop, and it advances once per beat.
// Reset clears the queue, the result valid flag and the bus state (SCL and
// SDA high, SDA driven) and loads delay_ticks with 500.
// A stall on res fills the two-entry queue, after which cmd_ready drops; a
// stall on cmd simply leaves the sequencer waiting.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
	input  logic                clk,
	input  logic                arst_n,
	// Tick beats.
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  i2cm_pkg::cmd_item_t cmd,
	// Result beats.
	output logic                res_valid,
	input  logic                res_ready,
	output i2cm_pkg::res_item_t res,
	// Configuration port.
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [i2cm_pkg::CFG_WIDTH-1:0] delay_q;
	i2cm_pkg::queue_head_t          head;
	logic                           pop;
	logic                           reg_sel;

	// The register index is the word address; only the delay register exists.
	assign reg_sel = (paddr[2] == i2cm_pkg::REG_DELAY);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? 32'(delay_q) : 32'd0;

	// Writes land in the access cycle of the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= i2cm_pkg::DELAY_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			delay_q <= pwdata[i2cm_pkg::CFG_WIDTH-1:0];
		end
	end

	// Front: takes beats, decodes the function code and queues them.
	i2cm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.head      (head),
		.pop       (pop)
	);

	// Back: runs the phase machine and holds the result beat.
	i2cm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.delay_ticks (delay_q),
		.head        (head),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

endmodule
